// ===== design/stcm_pkg.sv =====
// Shared types, constants and the character slot map of the trie matcher.
package stcm_pkg;

    localparam int FUNC_W     = 2;
    localparam int NODE_IDX_W = 13;
    localparam int SLOT_W     = 6;
    localparam int CODE_W     = 21;
    localparam int CHAR_W     = 8;
    localparam int LIMIT_W    = 17;
    localparam int MAX_NODES  = 1 << NODE_IDX_W;
    localparam int KEY_SLOTS  = 61;
    localparam int OUT_DEPTH  = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LINK  = 2'd0,
        FUNC_ENTRY = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [NODE_IDX_W-1:0] node_index;
        logic [SLOT_W-1:0]     slot;
        logic [NODE_IDX_W-1:0] child_link;
        logic [CODE_W-1:0]     first_code;
        logic [CODE_W-1:0]     second_code;
        logic                  terminal;
        logic [CHAR_W-1:0]     char_code;
        logic                  is_last;
    } item_t;

    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] first_code_out;
        logic [CODE_W-1:0] second_code_out;
    } result_t;

    typedef struct packed {
        logic              terminal;
        logic [CODE_W-1:0] second_code;
        logic [CODE_W-1:0] first_code;
    } node_entry_t;

    // last character leaving the walk stage
    typedef struct packed {
        logic                  valid;
        logic                  failed;
        logic [NODE_IDX_W-1:0] node;
    } walk_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } slot_map_t;

    // '1'..'8' -> 0..7, 'A'..'Z' -> 8..33, 'a'..'z' -> 34..59, ';' -> 60
    function automatic slot_map_t char_slot(input logic [CHAR_W-1:0] c);
        slot_map_t r;
        r = '0;
        if (c >= 8'd49 && c <= 8'd56)
        begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(c - 8'd49);
        end
        else if (c >= 8'd65 && c <= 8'd90)
        begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(c - 8'd57);
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(c - 8'd63);
        end
        else if (c == 8'd59)
        begin
            r.hit = 1'b1;
            r.idx = SLOT_W'(KEY_SLOTS - 1);
        end
        return r;
    endfunction

endpackage

// ===== design/stcm_stream_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
interface stcm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/static_trie_char_matcher.sv =====
// Top level of the flattened trie name matcher.
// Takes one beat per cycle unless stalled, loads and query characters alike. A load writes its
// memory in the cycle it is accepted. A query character reads the child-link memory (64 slots per
// node row, address {node, slot}); the registered read data is checked and forwarded straight into
// the address of the next character, so characters stream back to back. On the last character the
// node entry memory is read in the following cycle; the result is queued once that read data is
// registered and leaves on the result channel from the next cycle. A four-entry result queue lets
// input beats continue while results wait; input stalls only when that queue and the results in
// flight would fill it. Loads with an out-of-range node or slot are ignored, as is func 3.
module static_trie_char_matcher #(
    parameter int NUM_NODES = 8192
) (
    input  logic          clk,
    input  logic          rst_n,
    stcm_stream_if.sink   item,
    stcm_stream_if.source result
);
    import stcm_pkg::*;

    localparam logic [LIMIT_W-1:0] NODE_LIMIT = LIMIT_W'(NUM_NODES);

    logic             acc;
    logic             node_ok;
    logic             link_we;
    logic             entry_we;
    logic             query_v;
    logic             acc_last;
    walk_t            walk;
    logic             res_v;
    result_t          res;
    logic [CNT_W-1:0] fifo_count;
    logic [CNT_W-1:0] inflight;

    always_comb
    begin
        inflight   = fifo_count + CNT_W'(walk.valid) + CNT_W'(res_v);
        item.ready = (inflight < CNT_W'(OUT_DEPTH));
        acc        = item.valid && item.ready;
        node_ok    = (LIMIT_W'(item.payload.node_index) < NODE_LIMIT);
        link_we    = acc && (item.payload.func == FUNC_LINK) && node_ok &&
                     (item.payload.slot < SLOT_W'(KEY_SLOTS));
        entry_we   = acc && (item.payload.func == FUNC_ENTRY) && node_ok;
        query_v    = acc && (item.payload.func == FUNC_QUERY);
        acc_last   = query_v && item.payload.is_last;
    end

    stcm_walk #(
        .NUM_NODES  (NUM_NODES)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .link_we    (link_we),
        .query_v    (query_v),
        .node_index (item.payload.node_index),
        .slot       (item.payload.slot),
        .child_link (item.payload.child_link),
        .char_code  (item.payload.char_code),
        .is_last    (item.payload.is_last),
        .walk       (walk)
    );

    stcm_entry #(
        .NUM_NODES   (NUM_NODES)
    ) u_entry (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_we    (entry_we),
        .node_index  (item.payload.node_index),
        .first_code  (item.payload.first_code),
        .second_code (item.payload.second_code),
        .terminal    (item.payload.terminal),
        .walk        (walk),
        .res_v       (res_v),
        .res         (res)
    );

    stcm_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (res_v),
        .din    (res),
        .count  (fifo_count),
        .result (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (fifo_count + CNT_W'(walk.valid) + CNT_W'(res_v)) <= CNT_W'(OUT_DEPTH))
        else $error("result queue plus in-flight results exceed queue depth");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n, 1) && $past(rst_n, 2)) |-> (res_v == $past(acc_last, 2)))
        else $error("result not queued exactly two cycles after a last character");

endmodule

// ===== design/stcm_walk.sv =====
// Child-link memory and the per-character trie walk with next-address forwarding.
module stcm_walk #(
    parameter int NUM_NODES = 8192
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              link_we,
    input  logic                              query_v,
    input  logic [stcm_pkg::NODE_IDX_W-1:0]   node_index,
    input  logic [stcm_pkg::SLOT_W-1:0]       slot,
    input  logic [stcm_pkg::NODE_IDX_W-1:0]   child_link,
    input  logic [stcm_pkg::CHAR_W-1:0]       char_code,
    input  logic                              is_last,
    output stcm_pkg::walk_t                   walk
);
    import stcm_pkg::*;

    localparam int NODES     = (NUM_NODES < MAX_NODES) ? NUM_NODES : MAX_NODES;
    localparam int NODE_W    = $clog2(NODES);
    localparam int MEM_DEPTH = NODES << SLOT_W;
    localparam logic [LIMIT_W-1:0] NODE_LIMIT = LIMIT_W'(NUM_NODES);

    logic [NODE_IDX_W-1:0] child_mem [MEM_DEPTH];

    logic                  s1_v_reg;
    logic                  s1_last_reg;
    logic                  s1_skip_reg;
    logic [NODE_W-1:0]     s1_node_reg;
    logic [NODE_IDX_W-1:0] link_q_reg;
    logic [NODE_W-1:0]     cur_reg;
    logic [NODE_W-1:0]     cur_next;
    logic                  failed_reg;
    logic                  failed_next;

    slot_map_t             smap;
    logic                  link_bad;
    logic [NODE_W-1:0]     step_node;
    logic [NODE_W+SLOT_W-1:0] rd_addr;
    logic [NODE_W+SLOT_W-1:0] wr_addr;

    always_comb
    begin
        smap      = char_slot(char_code);
        link_bad  = s1_skip_reg || (link_q_reg == '0) ||
                    (LIMIT_W'(link_q_reg) >= NODE_LIMIT);
        step_node = link_bad ? s1_node_reg : link_q_reg[NODE_W-1:0];
        cur_next    = cur_reg;
        failed_next = failed_reg;
        if (s1_v_reg)
        begin
            if (s1_last_reg)
            begin
                cur_next    = '0;
                failed_next = 1'b0;
            end
            else
            begin
                cur_next    = step_node;
                failed_next = link_bad;
            end
        end
        rd_addr = {cur_next, smap.idx};
        wr_addr = {node_index[NODE_W-1:0], slot};

        walk.valid  = s1_v_reg && s1_last_reg;
        walk.failed = link_bad;
        walk.node   = NODE_IDX_W'(step_node);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s1_last_reg <= 1'b0;
            s1_skip_reg <= 1'b0;
            s1_node_reg <= '0;
            cur_reg     <= '0;
            failed_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg    <= query_v;
            s1_last_reg <= is_last;
            s1_skip_reg <= failed_next || !smap.hit;
            s1_node_reg <= cur_next;
            cur_reg     <= cur_next;
            failed_reg  <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            child_mem[wr_addr] <= child_link;
        end
        else if (query_v)
        begin
            link_q_reg <= child_mem[rd_addr];
        end
    end

endmodule

// ===== design/stcm_entry.sv =====
// Node entry memory and the found/code-point result stage.
module stcm_entry #(
    parameter int NUM_NODES = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            entry_we,
    input  logic [stcm_pkg::NODE_IDX_W-1:0] node_index,
    input  logic [stcm_pkg::CODE_W-1:0]     first_code,
    input  logic [stcm_pkg::CODE_W-1:0]     second_code,
    input  logic                            terminal,
    input  stcm_pkg::walk_t                 walk,
    output logic                            res_v,
    output stcm_pkg::result_t               res
);
    import stcm_pkg::*;

    localparam int NODES  = (NUM_NODES < MAX_NODES) ? NUM_NODES : MAX_NODES;
    localparam int NODE_W = $clog2(NODES);

    node_entry_t entry_mem [NODES];

    logic        s2_v_reg;
    logic        s2_fail_reg;
    node_entry_t ent_q_reg;
    node_entry_t wr_data;
    logic        hit;

    always_comb
    begin
        wr_data.terminal    = terminal;
        wr_data.second_code = second_code;
        wr_data.first_code  = first_code;
        hit   = !s2_fail_reg && ent_q_reg.terminal;
        res_v = s2_v_reg;
        res.found           = hit;
        res.first_code_out  = hit ? ent_q_reg.first_code : '0;
        res.second_code_out = hit ? ent_q_reg.second_code : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg    <= 1'b0;
            s2_fail_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg    <= walk.valid;
            s2_fail_reg <= walk.failed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[node_index[NODE_W-1:0]] <= wr_data;
        end
        if (walk.valid)
        begin
            ent_q_reg <= entry_mem[walk.node[NODE_W-1:0]];
        end
    end

endmodule

// ===== design/stcm_out_fifo.sv =====
// Small result queue that decouples the lookup pipeline from the result channel.
module stcm_out_fifo (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  stcm_pkg::result_t          din,
    output logic [stcm_pkg::CNT_W-1:0] count,
    stcm_stream_if.source              result
);
    import stcm_pkg::*;

    result_t          buf_reg [OUT_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    always_comb
    begin
        result.valid   = (count_reg != '0);
        result.payload = buf_reg[head_reg];
        pop            = result.valid && result.ready;
        count          = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + PTR_W'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[tail_reg] <= din;
        end
    end

endmodule
